/* sv/tpdp_pkg.sv */
package tpdp_pkg;

  localparam int ACT_WIDTH   = 16;
  localparam int ACC_WIDTH   = 32;
  localparam int NUM_ACTS    = 5;
  localparam int NUM_CODES   = 4;
  localparam int GROUP_WIDTH = ACT_WIDTH + $clog2(NUM_ACTS) + 1;
  localparam int BASE3_LIMIT = 243;
  localparam int BYTE_VALUES = 256;

  localparam logic [1:0] CODE_NEG = 2'b00;
  localparam logic [1:0] CODE_POS = 2'b10;

  typedef enum logic {
    MODE_BASE3 = 1'b0,
    MODE_2BIT  = 1'b1
  } pack_mode_e;

  typedef logic signed [ACT_WIDTH-1:0]   act_t;
  typedef act_t [NUM_ACTS-1:0]           act_vec_t;
  typedef logic signed [GROUP_WIDTH-1:0] group_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } wdigit_t;

  typedef wdigit_t [NUM_ACTS-1:0]   wvec_t;
  typedef wvec_t [BYTE_VALUES-1:0]  trit_lut_t;

  // base-3 decode table, built by counting up in base 3
  function automatic trit_lut_t build_trit_lut();
    trit_lut_t   lut;
    int unsigned dig [NUM_ACTS];
    logic        carry;
    for (int j = 0; j < NUM_ACTS; j++) begin
      dig[j] = 0;
    end
    for (int b = 0; b < BYTE_VALUES; b++) begin
      for (int j = 0; j < NUM_ACTS; j++) begin
        if (b < BASE3_LIMIT) begin
          lut[b][j].neg = (dig[j] == 0);
          lut[b][j].pos = (dig[j] == 2);
        end else begin
          lut[b][j] = '0;
        end
      end
      carry = 1'b1;
      for (int j = 0; j < NUM_ACTS; j++) begin
        if (carry) begin
          if (dig[j] == 2) begin
            dig[j] = 0;
          end else begin
            dig[j] = dig[j] + 1;
            carry  = 1'b0;
          end
        end
      end
    end
    return lut;
  endfunction

  localparam trit_lut_t TRIT_LUT = build_trit_lut();

endpackage

/* sv/ternary_packed_dot_product.sv */
// Streaming dot product of packed ternary weights with 16-bit signed activations.
// One item (a weight byte plus five activations) is accepted every cycle while
// in_stall_o is low; the item sits in an input register, where its weights are
// decoded and its group sum formed and folded into the saturating 32-bit accumulator,
// and a last item's row result is then registered in the output register.
// in_stall_o rises only when a last item is waiting for the output register to be
// taken. packing_mode selects base-3 (five trits per byte) or 2-bit packing and
// is to be written only while no row is in flight; cfg_ready_o is always high.
module ternary_packed_dot_product (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_packing_mode_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     weight_byte_i,
  input  tpdp_pkg::act_t act_0_i,
  input  tpdp_pkg::act_t act_1_i,
  input  tpdp_pkg::act_t act_2_i,
  input  tpdp_pkg::act_t act_3_i,
  input  tpdp_pkg::act_t act_4_i,
  input  logic           last_of_row_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tpdp_pkg::acc_t dot_value_o,
  output logic           saturated_o
);

  tpdp_pkg::pack_mode_e mode_q;

  logic               s1_valid_q, s1_valid_d;
  logic [7:0]         s1_byte_q;
  tpdp_pkg::act_vec_t s1_acts_q;
  logic               s1_last_q;

  tpdp_pkg::acc_t     run_q, run_d;
  logic               clip_q, clip_d;
  logic               out_valid_q, out_valid_d;
  tpdp_pkg::acc_t     out_sum_q;
  logic               out_sat_q;

  logic               in_xfer;
  logic               out_free;
  logic               adv;
  tpdp_pkg::group_t   group;
  logic signed [tpdp_pkg::ACC_WIDTH:0] wide_sum;
  tpdp_pkg::acc_t     sat_sum;
  logic               clipped;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tpdp_pkg::MODE_BASE3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= tpdp_pkg::pack_mode_e'(cfg_packing_mode_i);
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q    <= weight_byte_i;
      s1_acts_q[0] <= act_0_i;
      s1_acts_q[1] <= act_1_i;
      s1_acts_q[2] <= act_2_i;
      s1_acts_q[3] <= act_3_i;
      s1_acts_q[4] <= act_4_i;
      s1_last_q    <= last_of_row_i;
    end
  end

  tpdp_group_sum u_group_sum (
    .mode_i        (mode_q),
    .weight_byte_i (s1_byte_q),
    .acts_i        (s1_acts_q),
    .group_o       (group)
  );

  // saturating accumulate
  always_comb begin
    wide_sum = {run_q[tpdp_pkg::ACC_WIDTH-1], run_q}
             + {{(tpdp_pkg::ACC_WIDTH + 1 - tpdp_pkg::GROUP_WIDTH){group[tpdp_pkg::GROUP_WIDTH-1]}},
                group};
    clipped  = wide_sum[tpdp_pkg::ACC_WIDTH] != wide_sum[tpdp_pkg::ACC_WIDTH-1];
    if (!clipped) begin
      sat_sum = wide_sum[tpdp_pkg::ACC_WIDTH-1:0];
    end else if (wide_sum[tpdp_pkg::ACC_WIDTH]) begin
      sat_sum = {1'b1, {(tpdp_pkg::ACC_WIDTH-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(tpdp_pkg::ACC_WIDTH-1){1'b1}}};
    end
  end

  always_comb begin
    run_d       = run_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) begin
      if (s1_last_q) begin
        run_d       = '0;
        clip_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        run_d  = sat_sum;
        clip_d = clip_q || clipped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_last_q) begin
      out_sum_q <= sat_sum;
      out_sat_q <= clip_q || clipped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_value_o = out_sum_q;
  assign saturated_o = out_sat_q;

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_last_q |=> run_q == '0 && !clip_q)
    else $error("accumulator not cleared after row result");

  a_sum_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(run_q) && $stable(clip_q))
    else $error("accumulator changed without an item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked row result");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && s1_last_q))
    else $error("result raised without a last item");

endmodule

/* sv/tpdp_group_sum.sv */
module tpdp_group_sum (
  input  tpdp_pkg::pack_mode_e mode_i,
  input  logic [7:0]           weight_byte_i,
  input  tpdp_pkg::act_vec_t   acts_i,
  output tpdp_pkg::group_t     group_o
);

  tpdp_pkg::wvec_t  weights;
  tpdp_pkg::group_t sum;
  tpdp_pkg::act_t   act;
  tpdp_pkg::group_t act_ext;

  // weight decode
  always_comb begin
    weights = '0;
    case (mode_i)
      tpdp_pkg::MODE_BASE3: begin
        weights = tpdp_pkg::TRIT_LUT[weight_byte_i];
      end
      tpdp_pkg::MODE_2BIT: begin
        for (int j = 0; j < tpdp_pkg::NUM_CODES; j++) begin
          weights[j].neg = (weight_byte_i[2*j +: 2] == tpdp_pkg::CODE_NEG);
          weights[j].pos = (weight_byte_i[2*j +: 2] == tpdp_pkg::CODE_POS);
        end
      end
      default: begin
        weights = '0;
      end
    endcase
  end

  // signed add/subtract of the activations
  always_comb begin
    sum     = '0;
    act     = '0;
    act_ext = '0;
    for (int j = 0; j < tpdp_pkg::NUM_ACTS; j++) begin
      act     = acts_i[j];
      act_ext = {{(tpdp_pkg::GROUP_WIDTH - tpdp_pkg::ACT_WIDTH){act[tpdp_pkg::ACT_WIDTH-1]}},
                 act};
      if (weights[j].pos) begin
        sum = sum + act_ext;
      end else if (weights[j].neg) begin
        sum = sum - act_ext;
      end
    end
  end

  assign group_o = sum;

endmodule
